// ===== hw/rtl/segment_rotate_translate_macros.svh =====
// Assertion helpers used by the checker file srt_checker.sv.
`ifndef SEGMENT_ROTATE_TRANSLATE_MACROS_SVH
`define SEGMENT_ROTATE_TRANSLATE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SRT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SRT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/srt_pkg.sv =====
package srt_pkg;

   // Default coordinate width and trig fraction width
   localparam int DEF_COORD_BITS     = 32;
   localparam int DEF_TRIG_FRAC_BITS = 14;

   // Four lane stages plus the merge/output stage
   localparam int NUM_STAGES   = 5;
   localparam int REG_IDX_BITS = 3;

   // Configuration register indexes
   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_COS_TILT = 3'd0,
      REG_SIN_TILT = 3'd1,
      REG_COS_TURN = 3'd2,
      REG_SIN_TURN = 3'd3,
      REG_SHIFT_X  = 3'd4,
      REG_SHIFT_Y  = 3'd5,
      REG_SHIFT_Z  = 3'd6
   } reg_index_type;

   // Per-stage advance enables handed from the pipeline control to the datapath
   typedef struct packed {
      logic [NUM_STAGES-1:0] adv;
   } pipe_ctl_type;

endpackage

// ===== hw/rtl/segment_rotate_translate.sv =====
// Segment rotate/translate engine.
// Request channel (req_*): one line segment per transaction, two endpoints in
// signed fixed point plus a final-segment marker. Each endpoint has x and z
// swapped, is rotated about y (tilt) and about z (turn), then offset.
// Response channel (rsp_*): the six transformed coordinates, the marker copy
// and a flag set when any coordinate was clipped to the output range.
// Both channels move a transaction on a clock edge with valid high, stall low.
// An accepted request is registered in the lane stages and then in the output
// register, whose valid bit drives rsp_valid.
// Throughput: one segment per cycle while rsp_stall stays low, set by the
// five-stage pipeline; the two endpoints run in two identical lanes, each with
// four multipliers per rotation stage.
// A stalled response holds in the output register; earlier stages keep
// accepting until they fill, so req_stall only rises once every stage holds a
// transaction.
// csr_*: register writes, made only while the block is idle; the user must keep
// to this, as the block itself does not enforce it. Reset (synchronous): empties
// the pipeline and loads identity rotation and zero offsets.
module segment_rotate_translate import srt_pkg::*; #(
   parameter int COORD_BITS     = DEF_COORD_BITS,
   parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS,
   localparam int T     = TRIG_FRAC_BITS + 2,
   localparam int CSR_W = (COORD_BITS > T) ? COORD_BITS : T
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_start_x,
   input  logic signed [COORD_BITS-1:0]  req_start_y,
   input  logic signed [COORD_BITS-1:0]  req_start_z,
   input  logic signed [COORD_BITS-1:0]  req_end_x,
   input  logic signed [COORD_BITS-1:0]  req_end_y,
   input  logic signed [COORD_BITS-1:0]  req_end_z,
   input  logic                          req_final_segment,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS-1:0]  rsp_new_start_x,
   output logic signed [COORD_BITS-1:0]  rsp_new_start_y,
   output logic signed [COORD_BITS-1:0]  rsp_new_start_z,
   output logic signed [COORD_BITS-1:0]  rsp_new_end_x,
   output logic signed [COORD_BITS-1:0]  rsp_new_end_y,
   output logic signed [COORD_BITS-1:0]  rsp_new_end_z,
   output logic                          rsp_final_out,
   output logic                          rsp_saturated,
   input  logic                          csr_wr_en,
   input  logic [REG_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_W-1:0]              csr_wdata
);

   localparam int C = COORD_BITS;
   localparam logic [T-1:0] TRIG_ONE = {2'b01, {TRIG_FRAC_BITS{1'b0}}};

   // Configuration registers
   logic signed [T-1:0] cos_tilt_ff, sin_tilt_ff, cos_turn_ff, sin_turn_ff;
   logic signed [C-1:0] shift_x_ff, shift_y_ff, shift_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_tilt_ff <= TRIG_ONE;
         sin_tilt_ff <= '0;
         cos_turn_ff <= TRIG_ONE;
         sin_turn_ff <= '0;
         shift_x_ff  <= '0;
         shift_y_ff  <= '0;
         shift_z_ff  <= '0;
      end else if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_COS_TILT: cos_tilt_ff <= csr_wdata[T-1:0];
            REG_SIN_TILT: sin_tilt_ff <= csr_wdata[T-1:0];
            REG_COS_TURN: cos_turn_ff <= csr_wdata[T-1:0];
            REG_SIN_TURN: sin_turn_ff <= csr_wdata[T-1:0];
            REG_SHIFT_X:  shift_x_ff  <= csr_wdata[C-1:0];
            REG_SHIFT_Y:  shift_y_ff  <= csr_wdata[C-1:0];
            REG_SHIFT_Z:  shift_z_ff  <= csr_wdata[C-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline control: a stage advances when empty or when the next one advances
   pipe_ctl_type          ctl;
   logic [NUM_STAGES-1:0] vld_ff, vld_in, vld_src;

   always_comb begin
      ctl.adv[NUM_STAGES-1] = ~vld_ff[NUM_STAGES-1] | ~rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         ctl.adv[i] = ~vld_ff[i] | ctl.adv[i+1];
      end
   end

   assign vld_src = {vld_ff[NUM_STAGES-2:0], req_valid};
   assign vld_in  = (ctl.adv & vld_src) | (~ctl.adv & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Carry the final-segment marker alongside the lane stages
   logic [NUM_STAGES-2:0] fin_ff;

   always_ff @(posedge clock) begin
      if (ctl.adv[0]) begin
         fin_ff[0] <= req_final_segment;
      end
      for (int i = 1; i < NUM_STAGES - 1; i++) begin
         if (ctl.adv[i]) begin
            fin_ff[i] <= fin_ff[i-1];
         end
      end
   end

   assign req_stall = ~ctl.adv[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   // One lane per endpoint
   logic signed [C+3:0] s_x2, s_y2, e_x2, e_y2;
   logic signed [C+2:0] s_z1, e_z1;

   srt_lane #(
      .COORD_BITS     (COORD_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_lane_start (
      .clock    (clock),
      .ctl      (ctl),
      .cos_tilt (cos_tilt_ff),
      .sin_tilt (sin_tilt_ff),
      .cos_turn (cos_turn_ff),
      .sin_turn (sin_turn_ff),
      .in_x     (req_start_x),
      .in_y     (req_start_y),
      .in_z     (req_start_z),
      .x2_out   (s_x2),
      .y2_out   (s_y2),
      .z1_out   (s_z1)
   );

   srt_lane #(
      .COORD_BITS     (COORD_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_lane_end (
      .clock    (clock),
      .ctl      (ctl),
      .cos_tilt (cos_tilt_ff),
      .sin_tilt (sin_tilt_ff),
      .cos_turn (cos_turn_ff),
      .sin_turn (sin_turn_ff),
      .in_x     (req_end_x),
      .in_y     (req_end_y),
      .in_z     (req_end_z),
      .x2_out   (e_x2),
      .y2_out   (e_y2),
      .z1_out   (e_z1)
   );

   // Offset, clip and combine both lanes into the response register
   srt_merge #(
      .COORD_BITS (COORD_BITS)
   ) u_merge (
      .clock       (clock),
      .ctl         (ctl),
      .shift_x     (shift_x_ff),
      .shift_y     (shift_y_ff),
      .shift_z     (shift_z_ff),
      .s_x2        (s_x2),
      .s_y2        (s_y2),
      .s_z1        (s_z1),
      .e_x2        (e_x2),
      .e_y2        (e_y2),
      .e_z1        (e_z1),
      .fin         (fin_ff[NUM_STAGES-2]),
      .new_start_x (rsp_new_start_x),
      .new_start_y (rsp_new_start_y),
      .new_start_z (rsp_new_start_z),
      .new_end_x   (rsp_new_end_x),
      .new_end_y   (rsp_new_end_y),
      .new_end_z   (rsp_new_end_z),
      .final_out   (rsp_final_out),
      .saturated   (rsp_saturated)
   );

endmodule

// ===== hw/rtl/srt_lane.sv =====
module srt_lane import srt_pkg::*; #(
   parameter int COORD_BITS     = DEF_COORD_BITS,
   parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS,
   localparam int T  = TRIG_FRAC_BITS + 2,
   localparam int C  = COORD_BITS
) (
   input  logic                  clock,
   input  pipe_ctl_type          ctl,
   input  logic signed [T-1:0]   cos_tilt,
   input  logic signed [T-1:0]   sin_tilt,
   input  logic signed [T-1:0]   cos_turn,
   input  logic signed [T-1:0]   sin_turn,
   input  logic signed [C-1:0]   in_x,
   input  logic signed [C-1:0]   in_y,
   input  logic signed [C-1:0]   in_z,
   output logic signed [C+3:0]   x2_out,
   output logic signed [C+3:0]   y2_out,
   output logic signed [C+2:0]   z1_out
);

   localparam int F  = TRIG_FRAC_BITS;
   localparam int P1 = C + T;        // first product width
   localparam int S1 = P1 + 1;       // first sum width
   localparam int R1 = S1 - F;       // x1/z1 width, C+3
   localparam int P2 = R1 + T;       // second product width
   localparam int S2 = P2 + 1;       // second sum width
   localparam int R2 = C + 4;        // x2/y2 width, C+4
   localparam logic [S1-1:0] HALF1 = {{(S1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
   localparam logic [S2-1:0] HALF2 = {{(S2-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

   // Stage 1: tilt products (x and z swapped on entry)
   logic signed [C-1:0]  px, pz;
   logic signed [P1-1:0] ctx_in, stz_in, ctz_in, stx_in;
   logic signed [P1-1:0] ctx_ff, stz_ff, ctz_ff, stx_ff;
   logic signed [C-1:0]  y1_ff;

   assign px     = in_z;
   assign pz     = in_x;
   assign ctx_in = cos_tilt * px;
   assign stz_in = sin_tilt * pz;
   assign ctz_in = cos_tilt * pz;
   assign stx_in = sin_tilt * px;

   always_ff @(posedge clock) begin
      if (ctl.adv[0]) begin
         ctx_ff <= ctx_in;
         stz_ff <= stz_in;
         ctz_ff <= ctz_in;
         stx_ff <= stx_in;
         y1_ff  <= in_y;
      end
   end

   // Stage 2: sum and round the tilt rotation
   logic signed [S1-1:0] sx1, sz1;
   logic signed [R1-1:0] x1_in, z1a_in;
   logic signed [R1-1:0] x1_ff, z1a_ff;
   logic signed [C-1:0]  y2a_ff;

   assign sx1    = S1'(ctx_ff) + S1'(stz_ff) + HALF1;
   assign sz1    = S1'(ctz_ff) - S1'(stx_ff) + HALF1;
   assign x1_in  = sx1[S1-1:F];
   assign z1a_in = sz1[S1-1:F];

   always_ff @(posedge clock) begin
      if (ctl.adv[1]) begin
         x1_ff  <= x1_in;
         z1a_ff <= z1a_in;
         y2a_ff <= y1_ff;
      end
   end

   // Stage 3: turn products
   logic signed [P2-1:0] cpx_in, spy_in, spx_in, cpy_in;
   logic signed [P2-1:0] cpx_ff, spy_ff, spx_ff, cpy_ff;
   logic signed [R1-1:0] z1b_ff;

   assign cpx_in = cos_turn * x1_ff;
   assign spy_in = sin_turn * y2a_ff;
   assign spx_in = sin_turn * x1_ff;
   assign cpy_in = cos_turn * y2a_ff;

   always_ff @(posedge clock) begin
      if (ctl.adv[2]) begin
         cpx_ff <= cpx_in;
         spy_ff <= spy_in;
         spx_ff <= spx_in;
         cpy_ff <= cpy_in;
         z1b_ff <= z1a_ff;
      end
   end

   // Stage 4: sum and round the turn rotation; the result always fits C+4 bits
   logic signed [S2-1:0] sx2, sy2;
   logic signed [R2-1:0] x2_in, y2_in;
   logic signed [R2-1:0] x2_ff, y2_ff;
   logic signed [R1-1:0] z1c_ff;

   assign sx2   = S2'(cpx_ff) - S2'(spy_ff) + HALF2;
   assign sy2   = S2'(spx_ff) + S2'(cpy_ff) + HALF2;
   assign x2_in = sx2[F+R2-1:F];
   assign y2_in = sy2[F+R2-1:F];

   always_ff @(posedge clock) begin
      if (ctl.adv[3]) begin
         x2_ff  <= x2_in;
         y2_ff  <= y2_in;
         z1c_ff <= z1b_ff;
      end
   end

   assign x2_out = x2_ff;
   assign y2_out = y2_ff;
   assign z1_out = z1c_ff;

endmodule

// ===== hw/rtl/srt_merge.sv =====
module srt_merge import srt_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS,
   localparam int C = COORD_BITS
) (
   input  logic                 clock,
   input  pipe_ctl_type         ctl,
   input  logic signed [C-1:0]  shift_x,
   input  logic signed [C-1:0]  shift_y,
   input  logic signed [C-1:0]  shift_z,
   input  logic signed [C+3:0]  s_x2,
   input  logic signed [C+3:0]  s_y2,
   input  logic signed [C+2:0]  s_z1,
   input  logic signed [C+3:0]  e_x2,
   input  logic signed [C+3:0]  e_y2,
   input  logic signed [C+2:0]  e_z1,
   input  logic                 fin,
   output logic signed [C-1:0]  new_start_x,
   output logic signed [C-1:0]  new_start_y,
   output logic signed [C-1:0]  new_start_z,
   output logic signed [C-1:0]  new_end_x,
   output logic signed [C-1:0]  new_end_y,
   output logic signed [C-1:0]  new_end_z,
   output logic                 final_out,
   output logic                 saturated
);

   localparam int W = C + 5;
   localparam logic [C-1:0] MAX_VAL = {1'b0, {(C-1){1'b1}}};
   localparam logic [C-1:0] MIN_VAL = {1'b1, {(C-1){1'b0}}};

   // Add the offsets at full width
   logic signed [W-1:0] sum_w [6];
   logic [C-1:0]        clip_w [6];
   logic [5:0]          ovf;

   assign sum_w[0] = W'(s_x2) + W'(shift_x);
   assign sum_w[1] = W'(s_y2) + W'(shift_y);
   assign sum_w[2] = W'(s_z1) + W'(shift_z);
   assign sum_w[3] = W'(e_x2) + W'(shift_x);
   assign sum_w[4] = W'(e_y2) + W'(shift_y);
   assign sum_w[5] = W'(e_z1) + W'(shift_z);

   // Clip each coordinate to the signed output range
   for (genvar k = 0; k < 6; k++) begin : g_clip
      assign ovf[k]    = (|sum_w[k][W-1:C-1]) & ~(&sum_w[k][W-1:C-1]);
      assign clip_w[k] = ovf[k] ? (sum_w[k][W-1] ? MIN_VAL : MAX_VAL) : sum_w[k][C-1:0];
   end

   // Output register: load whenever the previous transaction is gone
   logic signed [C-1:0] sx_ff, sy_ff, sz_ff, ex_ff, ey_ff, ez_ff;
   logic                fin_ff, sat_ff;

   always_ff @(posedge clock) begin
      if (ctl.adv[NUM_STAGES-1]) begin
         sx_ff  <= clip_w[0];
         sy_ff  <= clip_w[1];
         sz_ff  <= clip_w[2];
         ex_ff  <= clip_w[3];
         ey_ff  <= clip_w[4];
         ez_ff  <= clip_w[5];
         fin_ff <= fin;
         sat_ff <= |ovf;
      end
   end

   assign new_start_x = sx_ff;
   assign new_start_y = sy_ff;
   assign new_start_z = sz_ff;
   assign new_end_x   = ex_ff;
   assign new_end_y   = ey_ff;
   assign new_end_z   = ez_ff;
   assign final_out   = fin_ff;
   assign saturated   = sat_ff;

endmodule

// ===== hw/rtl/srt_checker.sv =====
`include "segment_rotate_translate_macros.svh"

module srt_checker import srt_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [COORD_BITS-1:0]  rsp_new_start_x,
   input logic                          rsp_saturated
);

   // Empty pipeline right after reset
   `SRT_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid after reset")

   // A free response side never backs up the request side
   `SRT_ASSERT_ALWAYS(a_no_stall_free, !rsp_stall |-> !req_stall, "request stalled without cause")

   // A stalled response holds
   `SRT_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_start_x) && $stable(rsp_saturated), "stalled response changed")

   // An accepted request reaches rsp_valid when the response side keeps moving
   `SRT_ASSERT(a_latency, req_valid && !req_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid, "response missing after pipeline latency")

endmodule

bind segment_rotate_translate srt_checker #(
   .COORD_BITS (COORD_BITS)
) u_srt_checker (.*);

// ===== dv/srt_transform_checker.sv =====
module srt_transform_checker import srt_pkg::*; #(
   parameter int COORD_BITS     = DEF_COORD_BITS,
   parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS,
   localparam int T     = TRIG_FRAC_BITS + 2,
   localparam int CSR_W = (COORD_BITS > T) ? COORD_BITS : T
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_start_z,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic signed [COORD_BITS-1:0] req_end_z,
   input  logic                         req_final_segment,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic signed [COORD_BITS-1:0] rsp_new_start_x,
   input  logic signed [COORD_BITS-1:0] rsp_new_start_y,
   input  logic signed [COORD_BITS-1:0] rsp_new_start_z,
   input  logic signed [COORD_BITS-1:0] rsp_new_end_x,
   input  logic signed [COORD_BITS-1:0] rsp_new_end_y,
   input  logic signed [COORD_BITS-1:0] rsp_new_end_z,
   input  logic                         rsp_final_out,
   input  logic                         rsp_saturated,
   input  logic                         csr_wr_en,
   input  logic [REG_IDX_BITS-1:0]      csr_index,
   input  logic [CSR_W-1:0]             csr_wdata,
   output int                           mismatch_count,
   output int                           in_flight,
   output int                           segments_checked,
   output int                           clipped_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [COORD_BITS-1:0] sx, sy, sz, ex, ey, ez;
      logic                         final_seg;
      logic                         clipped;
   } moved_segment_type;

   // Shadow copy of the rotation and offset registers
   logic signed [T-1:0]          cos_tilt, sin_tilt, cos_turn, sin_turn;
   logic signed [COORD_BITS-1:0] shift_x, shift_y, shift_z;

   moved_segment_type transformed_q[$];

   // Drop the trig fraction, rounding half toward plus infinity
   function automatic longint descale(input longint v);
      return (v + (longint'(1) << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
   endfunction

   // Clip a final sum to the coordinate range and flag the clip
   function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v,
                                                                inout logic hit);
      longint hi, lo;
      hi = (longint'(1) << (COORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         hit = 1'b1;
         return COORD_BITS'(hi);
      end
      if (v < lo) begin
         hit = 1'b1;
         return COORD_BITS'(lo);
      end
      return COORD_BITS'(v);
   endfunction

   // Swap x/z, tilt about y, turn about z, then add the offset
   function automatic void move_point(input longint in_x, in_y, in_z,
                                      output logic signed [COORD_BITS-1:0] out_x,
                                      output logic signed [COORD_BITS-1:0] out_y,
                                      output logic signed [COORD_BITS-1:0] out_z,
                                      inout logic hit);
      longint x, y, z, x1, z1, x2, y2, ct, st, cp, sp;
      x  = in_z;
      y  = in_y;
      z  = in_x;
      ct = cos_tilt;
      st = sin_tilt;
      cp = cos_turn;
      sp = sin_turn;
      x1 = descale(ct * x + st * z);
      z1 = descale(ct * z - st * x);
      x2 = descale(cp * x1 - sp * y);
      y2 = descale(sp * x1 + cp * y);
      out_x = clamp_coord(x2 + shift_x, hit);
      out_y = clamp_coord(y2 + shift_y, hit);
      out_z = clamp_coord(z1 + shift_z, hit);
   endfunction

   function automatic moved_segment_type predict_segment();
      moved_segment_type m;
      m.clipped = 1'b0;
      move_point(req_start_x, req_start_y, req_start_z, m.sx, m.sy, m.sz, m.clipped);
      move_point(req_end_x, req_end_y, req_end_z, m.ex, m.ey, m.ez, m.clipped);
      m.final_seg = req_final_segment;
      return m;
   endfunction

   task automatic check_field(input string field, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      moved_segment_type want;
      if (reset) begin
         cos_tilt = T'(1 << TRIG_FRAC_BITS);
         sin_tilt = '0;
         cos_turn = T'(1 << TRIG_FRAC_BITS);
         sin_turn = '0;
         shift_x  = '0;
         shift_y  = '0;
         shift_z  = '0;
         transformed_q.delete();
      end else begin
         // Predict with the settings in force before this edge
         if (req_valid && !req_stall)
            transformed_q.push_back(predict_segment());

         // Track register writes; unknown indexes are ignored
         if (csr_wr_en) begin
            case (csr_index)
               REG_COS_TILT: cos_tilt = csr_wdata[T-1:0];
               REG_SIN_TILT: sin_tilt = csr_wdata[T-1:0];
               REG_COS_TURN: cos_turn = csr_wdata[T-1:0];
               REG_SIN_TURN: sin_turn = csr_wdata[T-1:0];
               REG_SHIFT_X:  shift_x  = csr_wdata[COORD_BITS-1:0];
               REG_SHIFT_Y:  shift_y  = csr_wdata[COORD_BITS-1:0];
               REG_SHIFT_Z:  shift_z  = csr_wdata[COORD_BITS-1:0];
               default: ;
            endcase
         end

         // Compare each accepted transaction with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (transformed_q.size() == 0) begin
               $error("result transaction arrived with no segment outstanding");
               mismatch_count++;
            end else begin
               want = transformed_q.pop_front();
               check_field("new_start_x", want.sx, rsp_new_start_x);
               check_field("new_start_y", want.sy, rsp_new_start_y);
               check_field("new_start_z", want.sz, rsp_new_start_z);
               check_field("new_end_x", want.ex, rsp_new_end_x);
               check_field("new_end_y", want.ey, rsp_new_end_y);
               check_field("new_end_z", want.ez, rsp_new_end_z);
               check_field("final_out", {63'd0, want.final_seg}, {63'd0, rsp_final_out});
               check_field("saturated", {63'd0, want.clipped}, {63'd0, rsp_saturated});
               segments_checked++;
               if (want.clipped)
                  clipped_count++;
            end
         end
      end
      in_flight = transformed_q.size();
   end

endmodule

// ===== dv/tb_segment_rotate_translate.sv =====
module tb_segment_rotate_translate;
   timeunit 1ns;
   timeprecision 1ps;

   import srt_pkg::*;

   localparam int CB    = DEF_COORD_BITS;
   localparam int TF    = DEF_TRIG_FRAC_BITS;
   localparam int T     = TF + 2;
   localparam int CSR_W = (CB > T) ? CB : T;

   localparam int CLOCK_PERIOD     = 8;
   localparam int TIMEOUT_NS       = 4_000_000;
   localparam int RANDOM_PHASES    = 8;
   localparam int SEGMENTS_PER_SET = 250;

   // Index past the last register; writes there must change nothing
   localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = '1;

   localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};
   localparam logic signed [T-1:0]  TRIG_ONE  = T'(1 << TF);
   localparam logic signed [T-1:0]  TRIG_HALF = T'(1 << (TF - 1));
   localparam logic signed [T-1:0]  TRIG_MAX  = {1'b0, {(T-1){1'b1}}};
   localparam logic signed [T-1:0]  TRIG_MIN  = {1'b1, {(T-1){1'b0}}};

   typedef struct {
      logic signed [CB-1:0] sx, sy, sz, ex, ey, ez;
      logic                 final_seg;
   } segment_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC
   } stall_mode_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [CB-1:0]    req_start_x = '0;
   logic signed [CB-1:0]    req_start_y = '0;
   logic signed [CB-1:0]    req_start_z = '0;
   logic signed [CB-1:0]    req_end_x = '0;
   logic signed [CB-1:0]    req_end_y = '0;
   logic signed [CB-1:0]    req_end_z = '0;
   logic                    req_final_segment = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [CB-1:0]    rsp_new_start_x;
   logic signed [CB-1:0]    rsp_new_start_y;
   logic signed [CB-1:0]    rsp_new_start_z;
   logic signed [CB-1:0]    rsp_new_end_x;
   logic signed [CB-1:0]    rsp_new_end_y;
   logic signed [CB-1:0]    rsp_new_end_z;
   logic                    rsp_final_out;
   logic                    rsp_saturated;
   logic                    csr_wr_en = 1'b0;
   logic [REG_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_W-1:0]        csr_wdata = '0;

   int mismatch_count;
   int in_flight;
   int segments_checked;
   int clipped_count;

   int             segments_sent = 0;
   int             settings_used = 1;
   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   int             stall_tick = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   segment_rotate_translate i_dut (.*);

   srt_transform_checker i_checker (.*);

   // Receiver: hold each randomly chosen stall pattern for a random run, then pick another
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_HALF:     rsp_stall <= ($urandom_range(0, 1) == 1);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
         STALL_PERIODIC: rsp_stall <= ((stall_tick % 7) < 3);
         default:        rsp_stall <= 1'b0;
      endcase
   end

   // Drive one transaction, hold it until taken, then maybe idle
   task automatic send_segment(input segment_type s);
      int gap;
      @(negedge clock);
      req_valid         <= 1'b1;
      req_start_x       <= s.sx;
      req_start_y       <= s.sy;
      req_start_z       <= s.sz;
      req_end_x         <= s.ex;
      req_end_y         <= s.ey;
      req_end_z         <= s.ez;
      req_final_segment <= s.final_seg;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      segments_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(0, 12);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1)
            @(negedge clock);
      end
   endtask

   task automatic send_coords(input logic signed [CB-1:0] sx, sy, sz, ex, ey, ez,
                              input logic fin);
      segment_type s;
      s = '{sx, sy, sz, ex, ey, ez, fin};
      send_segment(s);
   endtask

   // Hold off the sender until every outstanding segment has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (in_flight != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                            input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Trig registers get random junk above their width
   task automatic write_trig(input logic [REG_IDX_BITS-1:0] idx,
                             input logic signed [T-1:0] v);
      logic [CSR_W-1:0] value;
      value        = CSR_W'($urandom);
      value[T-1:0] = v;
      write_reg(idx, value);
   endtask

   task automatic load_settings(input logic signed [T-1:0] ct, st, cp, sp,
                                input logic signed [CB-1:0] ox, oy, oz);
      drain_results();
      write_trig(REG_COS_TILT, ct);
      write_trig(REG_SIN_TILT, st);
      write_trig(REG_COS_TURN, cp);
      write_trig(REG_SIN_TURN, sp);
      write_reg(REG_SHIFT_X, ox);
      write_reg(REG_SHIFT_Y, oy);
      write_reg(REG_SHIFT_Z, oz);
      settings_used++;
   endtask

   function automatic logic signed [CB-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0, 1: return CB'($urandom);
         2: return CB'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
         3: begin
            case ($urandom_range(0, 4))
               0: return COORD_MAX;
               1: return COORD_MIN;
               2: return '0;
               3: return '1;
               default: return CB'(1);
            endcase
         end
         4: return CB'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
         default: return CB'(int'($urandom_range(0, 32)) - 16);
      endcase
   endfunction

   function automatic segment_type rand_segment();
      segment_type s;
      s.sx        = rand_coord();
      s.sy        = rand_coord();
      s.sz        = rand_coord();
      s.ex        = rand_coord();
      s.ey        = rand_coord();
      s.ez        = rand_coord();
      s.final_seg = ($urandom_range(0, 7) == 0);
      return s;
   endfunction

   // Mostly proper angles, sometimes any 16-bit value
   function automatic logic signed [T-1:0] rand_trig();
      if ($urandom_range(0, 5) == 0)
         return T'($urandom);
      return T'(int'($urandom_range(0, 2 * (1 << TF))) - (1 << TF));
   endfunction

   function automatic logic signed [CB-1:0] rand_shift();
      case ($urandom_range(0, 3))
         0: return CB'($urandom);
         1: return '0;
         default: return CB'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      endcase
   endfunction

   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (5)
         @(negedge clock);
      reset <= 1'b0;

      // Identity rotation and zero offset straight out of reset
      send_coords('0, '0, '0, '0, '0, '0, 1'b0);
      send_coords(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
      send_coords(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
      send_coords(COORD_MAX, COORD_MIN, 1, -1, COORD_MAX, COORD_MIN, 1'b1);

      // Half-scale tilt: exact ties in the rounding, both signs
      load_settings(TRIG_HALF, '0, TRIG_ONE, '0, '0, '0, '0);
      send_coords(1, 7, 1, -1, -7, -1, 1'b0);
      send_coords(3, 5, 3, -3, -5, -3, 1'b1);

      // Full-scale trig and offsets at the range ends: clip both ways
      load_settings(-TRIG_ONE, TRIG_ONE, TRIG_ONE, -TRIG_ONE, COORD_MAX, COORD_MIN, COORD_MAX);
      send_coords('0, '0, '0, '0, '0, '0, 1'b0);
      send_coords(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      send_coords(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
      send_coords(16, -16, 32, -32, 64, -64, 1'b0);
      send_segment(rand_segment());

      // Trig beyond unit magnitude, plus a write to a missing register
      load_settings(TRIG_MIN, TRIG_MAX, TRIG_MAX, TRIG_MIN, COORD_MIN, COORD_MAX, COORD_MIN);
      write_reg(REG_UNUSED, CSR_W'($urandom));
      send_coords(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      send_coords(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      send_coords('0, '0, '0, '0, '0, '0, 1'b0);
      send_coords(1, -1, 1, -1, 1, -1, 1'b0);
      send_segment(rand_segment());

      // Quarter turns on both axes
      load_settings('0, TRIG_ONE, '0, TRIG_ONE, '0, '0, '0);
      send_coords(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
      send_coords(12345, -678, 91011, -1213, 1415, -1617, 1'b0);
      send_segment(rand_segment());

      // Random segments under a fresh random setting each phase
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_settings(rand_trig(), rand_trig(), rand_trig(), rand_trig(),
                       rand_shift(), rand_shift(), rand_shift());
         for (int i = 0; i < SEGMENTS_PER_SET; i++) begin
            if (p == 2 && i == SEGMENTS_PER_SET / 2)
               drain_results();
            send_segment(rand_segment());
         end
      end

      drain_results();
      repeat (NUM_STAGES + 3)
         @(posedge clock);
      $display("Sent %0d segments under %0d register settings; %0d results checked, %0d clipped.",
               segments_sent, settings_used, segments_checked, clipped_count);
      if (mismatch_count == 0 && in_flight == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
